[rtl/tshr_pkg.sv]
// Shared types and constants for the timestamped sample history ring.
// Used by tshr_ctrl, tshr_dp and timestamped_sample_history_ring_core.
package tshr_pkg;

	localparam int DEFAULT_SENSORS = 4;
	localparam int DEFAULT_DEPTH   = 64;

	localparam logic [15:0] MINUTES_PER_HOUR = 16'd60;

	localparam logic [2:0] ACT_LIVE       = 3'd0;
	localparam logic [2:0] ACT_INTERVAL   = 3'd1;
	localparam logic [2:0] ACT_UNTIMED    = 3'd2;
	localparam logic [2:0] ACT_CLEAR      = 3'd3;
	localparam logic [2:0] ACT_READ_ALL   = 3'd4;
	localparam logic [2:0] ACT_READ_FILT  = 3'd5;

	typedef struct packed {
		logic [2:0]         action;
		logic [1:0]         sensor;
		logic [15:0]        co2_value;
		logic signed [15:0] temperature_value;
		logic [15:0]        humidity_value;
		logic [15:0]        pressure_value;
		logic [7:0]         interval_minute;
		logic [15:0]        max_age;
	} in_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [15:0] co2_out;
		logic signed [15:0] temperature_out;
		logic signed [15:0] humidity_out;
		logic signed [15:0] pressure_out;
		logic [15:0]        age_minutes;
		logic [6:0]         record_count;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [15:0] co2;
		logic [15:0] temp;
		logic [15:0] hum;
		logic [15:0] pres;
		logic [15:0] stamp;
	} rec_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic emit_init;
		logic emit_step;
		logic empty_push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rd_all;
		logic rd_filt;
		logic rd_empty;
		logic last_idx;
		logic slot_free;
		logic none_found;
	} dp_stat_t;

endpackage

[rtl/timestamped_sample_history_ring_core.sv]
// Top level of the timestamped sample history ring.
// Depends on tshr_pkg, tshr_ctrl and tshr_dp.
//
// Each sensor keeps a ring of DEPTH records (four readings and a minute
// stamp) in one shared single-port-read record memory. Appends and clears
// may follow back to back. A read-all of n records is accepted and then
// issues one memory read per cycle while the output side keeps up, so its
// n results come out one per cycle. A filtered read first scans all n
// stored records through the same memory read port and settles the match
// count, then emits its run one record per cycle while the output side
// keeps up, or one empty result if nothing matched. An empty read gives
// one result. Results leave through a two-stage output pipe, so the block
// keeps working while a finished result waits to be taken. No input is
// taken while a read is scanning, issuing its run or pushing its result.
module timestamped_sample_history_ring_core #(
	parameter int SENSORS = tshr_pkg::DEFAULT_SENSORS,
	parameter int DEPTH   = tshr_pkg::DEFAULT_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tshr_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output tshr_pkg::out_t  out_data
);

	tshr_pkg::ctrl_cmd_t cmd;
	tshr_pkg::dp_stat_t  st;

	tshr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	tshr_dp #(
		.SENSORS (SENSORS),
		.DEPTH   (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_data)
	);

endmodule

[rtl/tshr_ctrl.sv]
// Sequencer for the history ring: accept, filter scan, run emission, empty result.
// Depends on tshr_pkg (ctrl_cmd_t, dp_stat_t).
module tshr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tshr_pkg::dp_stat_t   st,
	output tshr_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SCAN_END = 3'd2;
	localparam logic [2:0] S_SCAN_CHK = 3'd3;
	localparam logic [2:0] S_EMIT     = 3'd4;
	localparam logic [2:0] S_EMPTY    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.rd_all) begin
						state_nxt = S_EMIT;
					end else if (st.rd_filt) begin
						state_nxt = S_SCAN;
					end else if (st.rd_empty) begin
						state_nxt = S_EMPTY;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.last_idx) begin
					state_nxt = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_nxt = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (st.none_found) begin
					state_nxt = S_EMPTY;
				end else begin
					cmd.emit_init = 1'b1;
					state_nxt     = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit_step = 1'b1;
				if (st.slot_free && st.last_idx) begin
					state_nxt = S_IDLE;
				end
			end
			S_EMPTY: begin
				cmd.empty_push = 1'b1;
				if (st.slot_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/tshr_dp.sv]
// Datapath of the history ring: per-sensor state, record memory, scan
// counters and the two-stage output pipe. Depends on tshr_pkg.
module tshr_dp #(
	parameter int SENSORS = tshr_pkg::DEFAULT_SENSORS,
	parameter int DEPTH   = tshr_pkg::DEFAULT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tshr_pkg::in_t        in_item,
	input  tshr_pkg::ctrl_cmd_t  cmd,
	output tshr_pkg::dp_stat_t   st,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tshr_pkg::out_t       out_item
);

	localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_PTR = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL     = CW'(DEPTH);
	localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);

	// per-sensor state
	logic [IW-1:0] head_q [SENSORS];
	logic [CW-1:0] fill_q [SENSORS];
	logic [15:0]   mins_q [SENSORS];
	logic [7:0]    prev_q [SENSORS];

	tshr_pkg::rec_t mem [SENSORS][DEPTH];

	logic [SW-1:0] sidx;
	logic          ok;
	logic [IW-1:0] cur_head;
	logic [CW-1:0] cur_fill;
	logic [15:0]   cur_mins;
	logic [7:0]    cur_prev;
	logic [IW-1:0] head_nxt;
	logic [CW-1:0] fill_nxt;
	logic [15:0]   mins_new;
	logic [15:0]   elapsed;
	logic [IW-1:0] start;
	logic          is_app;
	logic          is_read;
	logic          has_data;
	tshr_pkg::rec_t wr_rec;

	// read-side state
	logic [SW-1:0] sel_q;
	logic [15:0]   snap_mins_q;
	logic [15:0]   limit_q;
	logic [IW-1:0] start_q;
	logic [CW-1:0] run_n_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_inc;
	logic [IW-1:0] k_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] first_q;
	logic          found_q;
	logic          scan_v_q;
	logic [15:0]   scan_stamp_q;
	logic [15:0]   age;
	logic          hit;
	logic [IW:0]   base_sum;
	logic [IW-1:0] base;
	logic          last_idx;

	// output pipe
	logic           v_s1;
	tshr_pkg::rec_t rec_s1;
	logic           empty_s1;
	logic           last_s1;
	logic [CW-1:0]  cnt_s1;
	logic [15:0]    mins_s1;
	logic           out_valid_q;
	tshr_pkg::out_t out_q;
	tshr_pkg::out_t out_nxt;
	logic           adv;
	logic           space;
	logic           issue;
	logic           emp;

	assign sidx     = SW'(in_item.sensor);
	assign ok       = (32'(in_item.sensor) < SENSORS);
	assign cur_head = head_q[sidx];
	assign cur_fill = fill_q[sidx];
	assign cur_mins = mins_q[sidx];
	assign cur_prev = prev_q[sidx];
	assign head_nxt = (cur_head == LAST_PTR) ? '0 : cur_head + 1'b1;
	assign fill_nxt = (cur_fill == FULL) ? cur_fill : cur_fill + 1'b1;
	assign start    = (cur_fill == FULL) ? cur_head : '0;
	assign has_data = ok && (cur_fill != '0);

	assign is_app  = ok && ((in_item.action == tshr_pkg::ACT_LIVE) ||
	                        (in_item.action == tshr_pkg::ACT_INTERVAL) ||
	                        (in_item.action == tshr_pkg::ACT_UNTIMED));
	assign is_read = (in_item.action == tshr_pkg::ACT_READ_ALL) ||
	                 (in_item.action == tshr_pkg::ACT_READ_FILT);

	always_comb begin
		if (in_item.interval_minute > cur_prev) begin
			elapsed = {8'd0, in_item.interval_minute - cur_prev};
		end else if (in_item.interval_minute < cur_prev) begin
			elapsed = tshr_pkg::MINUTES_PER_HOUR - {8'd0, cur_prev}
			          + {8'd0, in_item.interval_minute};
		end else begin
			elapsed = '0;
		end
	end

	always_comb begin
		mins_new     = cur_mins;
		wr_rec.co2   = in_item.co2_value;
		wr_rec.temp  = in_item.temperature_value;
		wr_rec.hum   = in_item.humidity_value;
		wr_rec.pres  = in_item.pressure_value;
		wr_rec.stamp = '0;
		case (in_item.action)
			tshr_pkg::ACT_LIVE: begin
				mins_new     = (cur_fill != '0) ? cur_mins + 16'd1 : cur_mins;
				wr_rec.stamp = mins_new;
			end
			tshr_pkg::ACT_INTERVAL: begin
				mins_new     = (cur_fill != '0) ? cur_mins + elapsed : '0;
				wr_rec.stamp = mins_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSORS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
				mins_q[i] <= '0;
				prev_q[i] <= '0;
			end
		end else if (cmd.accept && ok) begin
			if (is_app) begin
				head_q[sidx] <= head_nxt;
				fill_q[sidx] <= fill_nxt;
				mins_q[sidx] <= mins_new;
				if (in_item.action == tshr_pkg::ACT_INTERVAL) begin
					prev_q[sidx] <= in_item.interval_minute;
				end
			end else if (in_item.action == tshr_pkg::ACT_CLEAR) begin
				head_q[sidx] <= '0;
				fill_q[sidx] <= '0;
				mins_q[sidx] <= '0;
				prev_q[sidx] <= '0;
			end
		end
	end

	assign ptr_inc  = (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
	assign last_idx = ((CW'(k_q) + CW'(1)) == run_n_q);
	assign age      = snap_mins_q - scan_stamp_q;
	assign hit      = scan_v_q && (age <= limit_q);
	assign base_sum = {1'b0, start_q} + {1'b0, first_q};
	assign base     = (base_sum >= DEPTH_W) ? IW'(base_sum - DEPTH_W) : IW'(base_sum);

	assign adv   = !out_valid_q || !out_stall;
	assign space = !v_s1 || adv;
	assign issue = cmd.emit_step && space;
	assign emp   = cmd.empty_push && space;

	// record memory: one write port, one read port
	always_ff @(posedge clk) begin
		if (cmd.accept && is_app) begin
			mem[sidx][cur_head] <= wr_rec;
		end
		if (issue) begin
			rec_s1 <= mem[sel_q][ptr_q];
		end
		if (cmd.scan_step) begin
			scan_stamp_q <= mem[sel_q][ptr_q].stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sel_q       <= sidx;
			snap_mins_q <= cur_mins;
			limit_q     <= in_item.max_age;
			start_q     <= start;
			run_n_q     <= cur_fill;
			ptr_q       <= start;
		end else if (cmd.emit_init) begin
			run_n_q <= cnt_q;
			ptr_q   <= base;
		end else if (cmd.scan_step || issue) begin
			ptr_q <= ptr_inc;
		end
		if (cmd.scan_step) begin
			pos_q <= k_q;
		end
		if (hit && !found_q) begin
			first_q <= pos_q;
		end
		if (emp || issue) begin
			empty_s1 <= emp;
			last_s1  <= emp || last_idx;
			cnt_s1   <= run_n_q;
			mins_s1  <= snap_mins_q;
		end
		if (adv && v_s1) begin
			out_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			scan_v_q    <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				k_q     <= '0;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.emit_init) begin
					k_q <= '0;
				end else if (cmd.scan_step || issue) begin
					k_q <= k_q + 1'b1;
				end
				if (hit) begin
					cnt_q   <= cnt_q + 1'b1;
					found_q <= 1'b1;
				end
			end
			scan_v_q <= cmd.scan_step;
			if (emp || issue) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_comb begin
		out_nxt = '0;
		if (empty_s1) begin
			out_nxt.last = 1'b1;
		end else begin
			out_nxt.valid_res       = 1'b1;
			out_nxt.co2_out         = signed'(rec_s1.co2);
			out_nxt.temperature_out = signed'(rec_s1.temp);
			out_nxt.humidity_out    = signed'(rec_s1.hum);
			out_nxt.pressure_out    = signed'(rec_s1.pres);
			out_nxt.age_minutes     = mins_s1 - rec_s1.stamp;
			out_nxt.record_count    = 7'(cnt_s1);
			out_nxt.last            = last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		st            = '0;
		st.rd_all     = (in_item.action == tshr_pkg::ACT_READ_ALL) && has_data;
		st.rd_filt    = (in_item.action == tshr_pkg::ACT_READ_FILT) && has_data;
		st.rd_empty   = is_read && !has_data;
		st.last_idx   = last_idx;
		st.slot_free  = space;
		st.none_found = (cnt_q == '0);
	end

endmodule

[tb/history_ring_checker.sv]
// Checker for the timestamped sample history ring: watches both channels,
// predicts the result records of each input transfer and compares them.
// Depends on tshr_pkg.
`timescale 1ns / 1ps

module history_ring_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  tshr_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  tshr_pkg::out_t out_data,
	output int             fail_count,
	output int             pending
);
	import tshr_pkg::*;

	localparam int SENS = DEFAULT_SENSORS;
	localparam int DEP  = DEFAULT_DEPTH;

	rec_t        ring     [SENS][DEP];
	logic [5:0]  head     [SENS];
	logic [6:0]  fill     [SENS];
	logic [15:0] total    [SENS];
	logic [7:0]  prev_min [SENS];

	out_t expected_records[$];
	out_t want;
	int   errors = 0;

	assign fail_count = errors;

	task automatic push_empty();
		out_t r;
		r = '0;
		r.last = 1'b1;
		expected_records.push_back(r);
	endtask

	task automatic push_run(int s, int first, int n);
		out_t r;
		int start;
		int idx;
		start = (fill[s] < DEP) ? 0 : int'(head[s]);
		for (int k = 0; k < n; k++) begin
			idx = (start + first + k) % DEP;
			r.valid_res       = 1'b1;
			r.co2_out         = ring[s][idx].co2;
			r.temperature_out = ring[s][idx].temp;
			r.humidity_out    = ring[s][idx].hum;
			r.pressure_out    = ring[s][idx].pres;
			r.age_minutes     = total[s] - ring[s][idx].stamp;
			r.record_count    = 7'(n);
			r.last            = (k == n - 1);
			expected_records.push_back(r);
		end
	endtask

	task automatic store_record(int s, in_t it, logic [15:0] stamp);
		ring[s][head[s]] = '{co2: it.co2_value, temp: it.temperature_value,
			hum: it.humidity_value, pres: it.pressure_value, stamp: stamp};
		head[s] = (head[s] == 6'(DEP - 1)) ? '0 : head[s] + 6'd1;
		if (fill[s] < DEP)
			fill[s] = fill[s] + 7'd1;
	endtask

	task automatic predict_history(in_t it);
		int          s;
		int          n;
		int          start;
		int          idx;
		int          cnt;
		int          first;
		logic [15:0] elapsed;
		logic [15:0] age;
		s = int'(it.sensor);
		case (it.action)
			ACT_LIVE: begin
				if (fill[s] != 0)
					total[s] = total[s] + 16'd1;
				store_record(s, it, total[s]);
			end
			ACT_INTERVAL: begin
				if (fill[s] == 0) begin
					total[s] = '0;
				end else begin
					if (it.interval_minute > prev_min[s])
						elapsed = {8'd0, it.interval_minute} - {8'd0, prev_min[s]};
					else if (it.interval_minute < prev_min[s])
						elapsed = MINUTES_PER_HOUR - {8'd0, prev_min[s]}
							+ {8'd0, it.interval_minute};
					else
						elapsed = '0;
					total[s] = total[s] + elapsed;
				end
				prev_min[s] = it.interval_minute;
				store_record(s, it, total[s]);
			end
			ACT_UNTIMED: store_record(s, it, '0);
			ACT_CLEAR: begin
				head[s]     = '0;
				fill[s]     = '0;
				total[s]    = '0;
				prev_min[s] = '0;
			end
			ACT_READ_ALL: begin
				if (fill[s] == 0)
					push_empty();
				else
					push_run(s, 0, int'(fill[s]));
			end
			ACT_READ_FILT: begin
				n     = int'(fill[s]);
				start = (n < DEP) ? 0 : int'(head[s]);
				cnt   = 0;
				first = -1;
				for (int i = 0; i < n; i++) begin
					idx = (start + i) % DEP;
					age = total[s] - ring[s][idx].stamp;
					if (age <= it.max_age) begin
						if (first < 0)
							first = i;
						cnt++;
					end
				end
				if (cnt == 0)
					push_empty();
				else
					push_run(s, first, cnt);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENS; s++) begin
				head[s]     = '0;
				fill[s]     = '0;
				total[s]    = '0;
				prev_min[s] = '0;
			end
			expected_records.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_history(in_data);
			if (out_valid && !out_stall) begin
				if (expected_records.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = expected_records.pop_front();
					check_field("valid_res", 16'(want.valid_res), 16'(out_data.valid_res));
					check_field("co2_out", want.co2_out, out_data.co2_out);
					check_field("temperature_out", want.temperature_out,
						out_data.temperature_out);
					check_field("humidity_out", want.humidity_out, out_data.humidity_out);
					check_field("pressure_out", want.pressure_out, out_data.pressure_out);
					check_field("age_minutes", want.age_minutes, out_data.age_minutes);
					check_field("record_count", 16'(want.record_count),
						16'(out_data.record_count));
					check_field("last", 16'(want.last), 16'(out_data.last));
				end
			end
			pending <= expected_records.size();
		end
	end

endmodule

[tb/timestamped_sample_history_ring_core_tb.sv]
// Top of the history ring testbench: clock, reset, directed and random
// transfers with random gaps and stalls, watchdog and verdict.
// Depends on tshr_pkg, history_ring_checker and the ring core.
`timescale 1ns / 1ps

module timestamped_sample_history_ring_core_tb;
	import tshr_pkg::*;

	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int ITEMS = 430;
	localparam int LIMIT = 4000;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic in_valid = 1'b0;
	in_t  in_data  = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	out_t out_data;
	int   fail_count;
	int   pending;

	int   sent       = 0;
	bit   quiet      = 1'b0;
	int   stall_left = 0;
	int   next_stall;
	int   idle;

	timestamped_sample_history_ring_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	history_ring_checker ring_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic in_t item_of(logic [2:0] act, logic [1:0] s);
		in_t it;
		it.action            = act;
		it.sensor            = s;
		it.co2_value         = 16'($urandom);
		it.temperature_value = 16'($urandom);
		it.humidity_value    = 16'($urandom);
		it.pressure_value    = 16'($urandom);
		if ($urandom_range(0, 9) == 0)
			it.interval_minute = 8'($urandom_range(0, 255));
		else
			it.interval_minute = 8'($urandom_range(0, 59));
		case ($urandom_range(0, 3))
			0: it.max_age = '0;
			1: it.max_age = 16'($urandom_range(0, 80));
			2: it.max_age = '1;
			default: it.max_age = 16'($urandom);
		endcase
		return it;
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send(in_t it);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.action <= ACT_READ_FILT)
			sent++;
	endtask

	task automatic send_at(logic [2:0] act, logic [1:0] s, logic [15:0] arg);
		in_t it;
		it = item_of(act, s);
		it.interval_minute = arg[7:0];
		it.max_age         = arg;
		send(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic logic [2:0] append_mode();
		return 3'($urandom_range(ACT_LIVE, ACT_UNTIMED));
	endfunction

	function automatic in_t read_item(logic [1:0] s);
		return item_of($urandom_range(0, 1) ? ACT_READ_ALL : ACT_READ_FILT, s);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			next_stall = draw_wait();
			stall_left <= next_stall;
			out_stall  <= (next_stall != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end
	end

	initial begin
		idle = 0;
		while (idle < LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		in_t         it;
		int          pick;
		int          len;
		logic [1:0]  s;
		logic [2:0]  mode;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty reads
		send(item_of(ACT_READ_ALL, 2'd0));
		send_at(ACT_READ_FILT, 2'd1, '1);
		// field extremes, first live record takes no increment
		it = item_of(ACT_LIVE, 2'd0);
		it.co2_value = '1;
		it.temperature_value = 16'sh8000;
		it.humidity_value = '0;
		it.pressure_value = '1;
		send(it);
		it = item_of(ACT_LIVE, 2'd0);
		it.co2_value = '0;
		it.temperature_value = 16'sh7fff;
		it.humidity_value = '1;
		it.pressure_value = '0;
		send(it);
		// forward step, repeat, hour rollover, out-of-range minutes
		send_at(ACT_INTERVAL, 2'd0, 16'd50);
		send_at(ACT_INTERVAL, 2'd0, 16'd50);
		send_at(ACT_INTERVAL, 2'd0, 16'd10);
		send_at(ACT_INTERVAL, 2'd0, 16'd255);
		send_at(ACT_INTERVAL, 2'd0, 16'd3);
		send(item_of(ACT_UNTIMED, 2'd0));
		send(item_of(ACT_READ_ALL, 2'd0));
		send_at(ACT_READ_FILT, 2'd0, 16'd0);
		send_at(ACT_READ_FILT, 2'd0, 16'd30);
		send_at(ACT_READ_FILT, 2'd0, '1);
		// interval append on an empty ring
		send_at(ACT_INTERVAL, 2'd2, 16'd42);
		send_at(ACT_INTERVAL, 2'd2, 16'd45);
		send(item_of(ACT_LIVE, 2'd2));
		send_at(ACT_READ_FILT, 2'd2, 16'd1);
		// unused codes
		send(item_of(ACT_SPARE_A, 2'd3));
		send(item_of(ACT_SPARE_B, 2'd3));
		// clear, then restart
		send(item_of(ACT_CLEAR, 2'd0));
		send(item_of(ACT_READ_ALL, 2'd0));
		send(item_of(ACT_LIVE, 2'd0));
		send_at(ACT_READ_FILT, 2'd0, 16'd0);
		drain();

		sent = 0;
		while (sent < ITEMS) begin
			quiet = ($urandom_range(0, 4) == 0);
			pick  = $urandom_range(0, 99);
			s     = 2'($urandom_range(0, 3));
			if (pick < 45) begin
				len  = $urandom_range(1, 20);
				mode = append_mode();
				repeat (len)
					send(item_of(($urandom_range(0, 9) < 7) ? mode : append_mode(), s));
				send(read_item(s));
			end else if (pick < 65) begin
				send(read_item(s));
			end else if (pick < 70) begin
				send(item_of(ACT_CLEAR, s));
			end else if (pick < 80) begin
				send(item_of($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, s));
			end else if (pick < 92) begin
				// long fill, can wrap the ring
				len  = $urandom_range(60, 80);
				mode = append_mode();
				repeat (len)
					send(item_of(($urandom_range(0, 9) < 8) ? mode : append_mode(), s));
				send(item_of(ACT_READ_ALL, s));
				send(item_of(ACT_READ_FILT, s));
			end else begin
				drain();
				send(read_item(s));
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
